/* hw/rtl/tcw_pkg.sv */
// tcw_pkg: shared constants, control word type and microcode ROM for the
// text console writer. No dependencies; used by text_console_writer_core.

package tcw_pkg;

	// field widths of the ports
	localparam int CMD_W   = 2;
	localparam int CHAR_W  = 8;
	localparam int INDEX_W = 11;
	localparam int CELL_W  = 16;
	localparam int ATTR_W  = 8;

	// default geometry
	localparam int ROWS_DEF      = 25;
	localparam int COLUMNS_DEF   = 80;
	localparam int TAB_WIDTH_DEF = 8;

	// commands
	localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

	// character codes
	localparam logic [CHAR_W-1:0] CODE_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CODE_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CODE_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CODE_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CODE_BLANK = 8'h20;
	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

	// sequencer steps
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] S_INIT     = 4'd0;
	localparam logic [STEP_W-1:0] S_FETCH    = 4'd1;
	localparam logic [STEP_W-1:0] S_DISPATCH = 4'd2;
	localparam logic [STEP_W-1:0] S_PUT      = 4'd3;
	localparam logic [STEP_W-1:0] S_CHECK    = 4'd4;
	localparam logic [STEP_W-1:0] S_SC_PRIME = 4'd5;
	localparam logic [STEP_W-1:0] S_SC_COPY  = 4'd6;
	localparam logic [STEP_W-1:0] S_SC_FILL  = 4'd7;
	localparam logic [STEP_W-1:0] S_SC_DONE  = 4'd8;
	localparam logic [STEP_W-1:0] S_CLEAR    = 4'd9;
	localparam logic [STEP_W-1:0] S_POST     = 4'd10;
	localparam logic [STEP_W-1:0] S_RD_ISSUE = 4'd11;
	localparam logic [STEP_W-1:0] S_RD_POST  = 4'd12;

	// write select
	localparam logic [1:0] WR_NONE   = 2'd0;
	localparam logic [1:0] WR_PTR    = 2'd1;
	localparam logic [1:0] WR_CURSOR = 2'd2;

	// write data select
	localparam logic [1:0] WD_RESET = 2'd0;
	localparam logic [1:0] WD_BLANK = 2'd1;
	localparam logic [1:0] WD_CHAR  = 2'd2;
	localparam logic [1:0] WD_COPY  = 2'd3;

	// read select
	localparam logic [1:0] RD_NONE  = 2'd0;
	localparam logic [1:0] RD_SHIFT = 2'd1;
	localparam logic [1:0] RD_CELL  = 2'd2;

	// pointer ops
	localparam logic [1:0] P_NONE = 2'd0;
	localparam logic [1:0] P_INC  = 2'd1;
	localparam logic [1:0] P_STEP = 2'd2;

	// cursor ops
	localparam logic [1:0] CUR_NONE     = 2'd0;
	localparam logic [1:0] CUR_PUT      = 2'd1;
	localparam logic [1:0] CUR_HOME     = 2'd2;
	localparam logic [1:0] CUR_LAST_ROW = 2'd3;

	// jump kinds
	localparam logic [2:0] J_NEXT     = 3'd0;
	localparam logic [2:0] J_GOTO     = 3'd1;
	localparam logic [2:0] J_LOOP     = 3'd2; // cond ? target : next
	localparam logic [2:0] J_HOLD     = 3'd3; // cond ? stay : target
	localparam logic [2:0] J_DISPATCH = 3'd4;

	// jump conditions
	localparam logic [2:0] C_NONE          = 3'd0;
	localparam logic [2:0] C_NO_IN         = 3'd1;
	localparam logic [2:0] C_OUT_BUSY      = 3'd2;
	localparam logic [2:0] C_NOT_SHIFT_END = 3'd3;
	localparam logic [2:0] C_NOT_ALL_END   = 3'd4;
	localparam logic [2:0] C_ROW_OK        = 3'd5;

	typedef struct packed {
		logic              take;
		logic              post;
		logic              dsrc_ram;
		logic [1:0]        wr_sel;
		logic [1:0]        wd_sel;
		logic [1:0]        rd_sel;
		logic [1:0]        ptr_op;
		logic [1:0]        cur_op;
		logic [2:0]        jmp;
		logic [2:0]        cond;
		logic [STEP_W-1:0] target;
	} ctl_t;

	function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
		ctl_t c;
		c = '0;
		case (step)
			S_INIT: begin
				c.wr_sel = WR_PTR; c.wd_sel = WD_RESET; c.ptr_op = P_STEP;
				c.jmp = J_HOLD; c.cond = C_NOT_ALL_END; c.target = S_FETCH;
			end
			S_FETCH: begin
				c.take = 1'b1;
				c.jmp = J_HOLD; c.cond = C_NO_IN; c.target = S_DISPATCH;
			end
			S_DISPATCH: begin
				c.jmp = J_DISPATCH;
			end
			S_PUT: begin
				c.wr_sel = WR_CURSOR; c.wd_sel = WD_CHAR; c.cur_op = CUR_PUT;
				c.jmp = J_NEXT;
			end
			S_CHECK: begin
				c.jmp = J_LOOP; c.cond = C_ROW_OK; c.target = S_POST;
			end
			S_SC_PRIME: begin
				c.rd_sel = RD_SHIFT; c.jmp = J_NEXT;
			end
			S_SC_COPY: begin
				c.wr_sel = WR_PTR; c.wd_sel = WD_COPY; c.rd_sel = RD_SHIFT;
				c.ptr_op = P_INC;
				c.jmp = J_HOLD; c.cond = C_NOT_SHIFT_END; c.target = S_SC_FILL;
			end
			S_SC_FILL: begin
				c.wr_sel = WR_PTR; c.wd_sel = WD_BLANK; c.ptr_op = P_STEP;
				c.jmp = J_HOLD; c.cond = C_NOT_ALL_END; c.target = S_SC_DONE;
			end
			S_SC_DONE: begin
				c.cur_op = CUR_LAST_ROW; c.jmp = J_GOTO; c.target = S_POST;
			end
			S_CLEAR: begin
				c.wr_sel = WR_PTR; c.wd_sel = WD_BLANK; c.ptr_op = P_STEP;
				c.cur_op = CUR_HOME;
				c.jmp = J_HOLD; c.cond = C_NOT_ALL_END; c.target = S_POST;
			end
			S_POST: begin
				c.post = 1'b1;
				c.jmp = J_HOLD; c.cond = C_OUT_BUSY; c.target = S_FETCH;
			end
			S_RD_ISSUE: begin
				c.rd_sel = RD_CELL; c.jmp = J_NEXT;
			end
			S_RD_POST: begin
				c.post = 1'b1; c.dsrc_ram = 1'b1;
				c.jmp = J_HOLD; c.cond = C_OUT_BUSY; c.target = S_FETCH;
			end
			default: begin
				c.jmp = J_GOTO; c.target = S_FETCH;
			end
		endcase
		return c;
	endfunction

	function automatic logic [STEP_W-1:0] dispatch(input logic [CMD_W-1:0] cmd);
		logic [STEP_W-1:0] s;
		case (cmd)
			CMD_PUT:   s = S_PUT;
			CMD_CLEAR: s = S_CLEAR;
			CMD_READ:  s = S_RD_ISSUE;
			default:   s = S_POST;
		endcase
		return s;
	endfunction

endpackage

/* hw/rtl/tcw_ram.sv */
// tcw_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.

module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

/* hw/rtl/text_console_writer_core.sv */
// text_console_writer_core: text console screen store and cursor, run by a
// microcoded sequencer. Depends on tcw_pkg and tcw_ram.
//
// channel  | handshake             | payload
// ---------+-----------------------+--------------------------------------
// in       | in_valid / in_stall   | cmd, char_code, cell_index
// out      | out_valid / out_stall | cursor_index, cell_data
// cfg      | cfg_valid / cfg_ready | cfg_data (attribute register)
//
// Transaction length is set by the sequencer program and the single RAM
// write port: a clear writes every cell, and a put that scrolls moves or
// fills every cell, one cell moved or filled per cycle.
// After reset the screen is filled with blanks; in_stall stays high during
// that pass, cfg writes are taken as ever.
// A finished result waits in the output register; the next input is taken
// while it waits, and the sequencer only holds when a second result is
// ready before the first one has left. cfg_ready is always high.

module text_console_writer_core #(
	parameter int ROWS      = tcw_pkg::ROWS_DEF,
	parameter int COLUMNS   = tcw_pkg::COLUMNS_DEF,
	parameter int TAB_WIDTH = tcw_pkg::TAB_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// input transactions
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [tcw_pkg::CMD_W-1:0]    cmd,
	input  logic [tcw_pkg::CHAR_W-1:0]   char_code,
	input  logic [tcw_pkg::INDEX_W-1:0]  cell_index,
	// result transactions
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [tcw_pkg::INDEX_W-1:0]  cursor_index,
	output logic [tcw_pkg::CELL_W-1:0]   cell_data,
	// attribute register write
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [tcw_pkg::ATTR_W-1:0]   cfg_data
);

	localparam int CELL_COUNT = ROWS * COLUMNS;
	localparam int AW = $clog2(CELL_COUNT);            // cell address
	localparam int CW = $clog2(COLUMNS);               // column
	localparam int RW = $clog2(ROWS + 1);              // row, may hold ROWS
	localparam int NW = $clog2(COLUMNS + TAB_WIDTH + 1); // column before wrap
	localparam int XW = (AW > tcw_pkg::INDEX_W) ? AW : tcw_pkg::INDEX_W;

	localparam logic [AW-1:0] CELL_LAST  = AW'(CELL_COUNT - 1);
	localparam logic [AW-1:0] SHIFT_LAST = AW'((ROWS - 1) * COLUMNS - 1);
	localparam logic [AW-1:0] COLS_A     = AW'(COLUMNS);
	localparam logic [RW-1:0] ROWS_R     = RW'(ROWS);
	localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);
	localparam logic [NW-1:0] COLS_N     = NW'(COLUMNS);
	localparam logic [XW-1:0] COUNT_X    = XW'(CELL_COUNT);

	localparam logic [tcw_pkg::CELL_W-1:0] RESET_CELL =
		{tcw_pkg::ATTR_RESET, tcw_pkg::CODE_BLANK};

	// sequencer and datapath registers
	logic [tcw_pkg::STEP_W-1:0]  step_q, step_d;
	logic [AW-1:0]               ptr_q, ptr_d;
	logic [CW-1:0]               col_q;
	logic [RW-1:0]               row_q;
	logic [tcw_pkg::ATTR_W-1:0]  attr_q;
	logic [tcw_pkg::CMD_W-1:0]   cmd_q;
	logic [tcw_pkg::CHAR_W-1:0]  code_q;
	logic [tcw_pkg::INDEX_W-1:0] cell_q;
	logic                        out_valid_q;
	logic [tcw_pkg::INDEX_W-1:0] cursor_index_q;
	logic [tcw_pkg::CELL_W-1:0]  cell_data_q;

	tcw_pkg::ctl_t ctl;
	logic          cond_true;
	logic          out_busy;
	logic          post_ok;

	// cursor unit
	logic [NW-1:0] tab_n;
	logic [NW-1:0] col_n;
	logic [RW-1:0] row_n;
	logic          printable;
	logic [AW-1:0] cur_addr;
	logic          cell_ok;

	// RAM ports
	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	logic [tcw_pkg::CELL_W-1:0] ram_wdata;
	logic                       ram_re;
	logic [AW-1:0]              ram_raddr;
	logic [tcw_pkg::CELL_W-1:0] ram_rdata;

	assign ctl       = tcw_pkg::ucode(step_q);
	assign in_stall  = !ctl.take;
	assign cfg_ready = 1'b1;
	assign out_busy  = out_valid_q && out_stall;
	assign post_ok   = ctl.post && !out_busy;

	assign out_valid    = out_valid_q;
	assign cursor_index = cursor_index_q;
	assign cell_data    = cell_data_q;

	// linear cursor position, row*COLUMNS+col
	assign cur_addr  = AW'(row_q) * COLS_A + AW'(col_q);
	assign cell_ok   = XW'(cell_q) < COUNT_X;
	assign printable = code_q >= tcw_pkg::CODE_BLANK;

	// next tab stop: one compare per stop
	always_comb begin
		tab_n = NW'(TAB_WIDTH);
		for (int k = 1; k <= COLUMNS / TAB_WIDTH; k++) begin
			if (int'(col_q) >= k * TAB_WIDTH)
				tab_n = NW'((k + 1) * TAB_WIDTH);
		end
	end

	// cursor move for put character
	always_comb begin
		col_n = NW'(col_q);
		row_n = row_q;
		case (code_q)
			tcw_pkg::CODE_BS: begin
				if (col_q != '0)
					col_n = NW'(col_q) - NW'(1);
			end
			tcw_pkg::CODE_TAB: col_n = tab_n;
			tcw_pkg::CODE_CR:  col_n = '0;
			tcw_pkg::CODE_LF: begin
				col_n = '0;
				row_n = row_q + RW'(1);
			end
			default: begin
				if (printable)
					col_n = NW'(col_q) + NW'(1);
			end
		endcase
		// right edge wraps; row may reach ROWS, which triggers a scroll
		if (col_n >= COLS_N) begin
			col_n = '0;
			row_n = row_n + RW'(1);
		end
	end

	// jump condition
	always_comb begin
		case (ctl.cond)
			tcw_pkg::C_NO_IN:         cond_true = !in_valid;
			tcw_pkg::C_OUT_BUSY:      cond_true = out_busy;
			tcw_pkg::C_NOT_SHIFT_END: cond_true = ptr_q != SHIFT_LAST;
			tcw_pkg::C_NOT_ALL_END:   cond_true = ptr_q != CELL_LAST;
			tcw_pkg::C_ROW_OK:        cond_true = row_q < ROWS_R;
			default:                  cond_true = 1'b0;
		endcase
	end

	// next step
	always_comb begin
		case (ctl.jmp)
			tcw_pkg::J_NEXT:     step_d = step_q + tcw_pkg::STEP_W'(1);
			tcw_pkg::J_GOTO:     step_d = ctl.target;
			tcw_pkg::J_LOOP:
				step_d = cond_true ? ctl.target : step_q + tcw_pkg::STEP_W'(1);
			tcw_pkg::J_HOLD:     step_d = cond_true ? step_q : ctl.target;
			tcw_pkg::J_DISPATCH: step_d = tcw_pkg::dispatch(cmd_q);
			default:             step_d = tcw_pkg::S_FETCH;
		endcase
	end

	// sweep pointer: INC runs through the row shift, STEP wraps at the end
	always_comb begin
		case (ctl.ptr_op)
			tcw_pkg::P_INC:  ptr_d = ptr_q + AW'(1);
			tcw_pkg::P_STEP: ptr_d = (ptr_q == CELL_LAST) ? '0 : ptr_q + AW'(1);
			default:         ptr_d = ptr_q;
		endcase
	end

	// RAM control
	always_comb begin
		case (ctl.wr_sel)
			tcw_pkg::WR_PTR:    ram_we = 1'b1;
			tcw_pkg::WR_CURSOR: ram_we = printable;
			default:            ram_we = 1'b0;
		endcase
		ram_waddr = (ctl.wr_sel == tcw_pkg::WR_CURSOR) ? cur_addr : ptr_q;
		case (ctl.wd_sel)
			tcw_pkg::WD_RESET: ram_wdata = RESET_CELL;
			tcw_pkg::WD_BLANK: ram_wdata = {attr_q, tcw_pkg::CODE_BLANK};
			tcw_pkg::WD_CHAR:  ram_wdata = {attr_q, code_q};
			tcw_pkg::WD_COPY:  ram_wdata = ram_rdata;
			default:           ram_wdata = RESET_CELL;
		endcase
		// scroll reads one row ahead of the next write pointer value (ptr_d)
		case (ctl.rd_sel)
			tcw_pkg::RD_SHIFT: begin
				ram_re    = 1'b1;
				ram_raddr = ptr_d + COLS_A;
			end
			tcw_pkg::RD_CELL: begin
				ram_re    = cell_ok;
				ram_raddr = cell_ok ? AW'(cell_q) : '0;
			end
			default: begin
				ram_re    = 1'b0;
				ram_raddr = '0;
			end
		endcase
	end

	tcw_ram #(
		.WIDTH (tcw_pkg::CELL_W),
		.DEPTH (CELL_COUNT)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= tcw_pkg::S_INIT;
			ptr_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			attr_q      <= tcw_pkg::ATTR_RESET;
			out_valid_q <= 1'b0;
		end else begin
			step_q <= step_d;
			ptr_q  <= ptr_d;
			if (cfg_valid && cfg_ready)
				attr_q <= cfg_data;
			case (ctl.cur_op)
				tcw_pkg::CUR_PUT: begin
					col_q <= CW'(col_n);
					row_q <= row_n;
				end
				tcw_pkg::CUR_HOME: begin
					col_q <= '0;
					row_q <= '0;
				end
				tcw_pkg::CUR_LAST_ROW: row_q <= LAST_ROW;
				default: ;
			endcase
			if (post_ok)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.take && in_valid) begin
			cmd_q  <= cmd;
			code_q <= char_code;
			cell_q <= cell_index;
		end
		if (post_ok) begin
			cursor_index_q <= tcw_pkg::INDEX_W'(cur_addr);
			cell_data_q    <= (ctl.dsrc_ram && cell_ok) ? ram_rdata : '0;
		end
	end

endmodule

/* test/console_screen_checker.sv */
// console_screen_checker: watches the command, result and attribute channels of
// text_console_writer_core, predicts each result and compares it field by field.
// Depends on tcw_pkg.

module console_screen_checker
	import tcw_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [CMD_W-1:0]   cmd,
	input  logic [CHAR_W-1:0]  char_code,
	input  logic [INDEX_W-1:0] cell_index,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [INDEX_W-1:0] cursor_index,
	input  logic [CELL_W-1:0]  cell_data,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [ATTR_W-1:0]  cfg_data,
	output int                 mismatches,
	output int                 outstanding
);

	localparam int CELLS = ROWS_DEF * COLUMNS_DEF;

	typedef struct packed {
		logic [INDEX_W-1:0] cursor;
		logic [CELL_W-1:0]  data;
	} console_result_t;

	logic [CELL_W-1:0] screen [CELLS];
	int unsigned       col_pos;
	int unsigned       row_pos;
	logic [ATTR_W-1:0] attr_reg;
	console_result_t   awaited_results [$];
	console_result_t   due_result;

	// Applies one command to the shadow screen and returns what the block owes.
	function automatic console_result_t run_console_cmd(input logic [CMD_W-1:0] op,
			input logic [CHAR_W-1:0] code, input logic [INDEX_W-1:0] where);
		console_result_t r;
		r.data = '0;
		case (op)
			CMD_PUT: begin
				if (code == CODE_BS) begin
					if (col_pos != 0)
						col_pos--;
				end else if (code == CODE_TAB) begin
					col_pos = (col_pos / TAB_WIDTH_DEF + 1) * TAB_WIDTH_DEF;
				end else if (code == CODE_CR) begin
					col_pos = 0;
				end else if (code == CODE_LF) begin
					col_pos = 0;
					row_pos++;
				end else if (code >= CODE_BLANK) begin
					screen[row_pos * COLUMNS_DEF + col_pos] = {attr_reg, code};
					col_pos++;
				end
				if (col_pos >= COLUMNS_DEF) begin
					col_pos = 0;
					row_pos++;
				end
				// scroll up one row, new bottom row blank in the current attribute
				if (row_pos >= ROWS_DEF) begin
					for (int i = 0; i < CELLS - COLUMNS_DEF; i++)
						screen[i] = screen[i + COLUMNS_DEF];
					for (int i = CELLS - COLUMNS_DEF; i < CELLS; i++)
						screen[i] = {attr_reg, CODE_BLANK};
					row_pos = ROWS_DEF - 1;
				end
			end
			CMD_CLEAR: begin
				for (int i = 0; i < CELLS; i++)
					screen[i] = {attr_reg, CODE_BLANK};
				col_pos = 0;
				row_pos = 0;
			end
			CMD_READ: begin
				if (where < CELLS)
					r.data = screen[where];
			end
			default: ;
		endcase
		r.cursor = INDEX_W'(row_pos * COLUMNS_DEF + col_pos);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CELLS; i++)
				screen[i] = {ATTR_RESET, CODE_BLANK};
			col_pos = 0;
			row_pos = 0;
			attr_reg = ATTR_RESET;
			awaited_results.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			// a result leaving now belongs to an earlier command, so check it first
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					$error("unexpected result: cursor_index %0d cell_data 0x%04h",
						cursor_index, cell_data);
					mismatches++;
				end else begin
					due_result = awaited_results.pop_front();
					if (cursor_index !== due_result.cursor) begin
						$error("cursor_index: expected %0d, actual %0d",
							due_result.cursor, cursor_index);
						mismatches++;
					end
					if (cell_data !== due_result.data) begin
						$error("cell_data: expected 0x%04h, actual 0x%04h",
							due_result.data, cell_data);
						mismatches++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				attr_reg = cfg_data;
			if (in_valid && !in_stall)
				awaited_results.push_back(run_console_cmd(cmd, char_code, cell_index));
			outstanding = awaited_results.size();
		end
	end

endmodule

/* test/testbench.sv */
// testbench: top of the text console writer test. Drives command transactions
// and attribute writes into text_console_writer_core and gives the verdict.
// Depends on tcw_pkg, text_console_writer_core and console_screen_checker.

module testbench;
	import tcw_pkg::*;

	localparam int CELLS = ROWS_DEF * COLUMNS_DEF;
	// command code the block does not use; must answer with the cursor only
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	// A scroll or clear walks the whole screen, as does the blank fill after
	// reset; STALL_LIMIT lies well above such a walk to cover any quiet stretch.
	localparam int STALL_LIMIT      = 20000;
	localparam int DRAIN_CYCLES     = 50;
	localparam int RANDOM_PER_PHASE = 170;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [CMD_W-1:0]   cmd = '0;
	logic [CHAR_W-1:0]  char_code = '0;
	logic [INDEX_W-1:0] cell_index = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [INDEX_W-1:0] cursor_index;
	logic [CELL_W-1:0]  cell_data;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [ATTR_W-1:0]  cfg_data = '0;

	int mismatches;
	int outstanding;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int quiet_cycles = 0;

	always #5 clk = ~clk;

	text_console_writer_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.char_code    (char_code),
		.cell_index   (cell_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.cursor_index (cursor_index),
		.cell_data    (cell_data),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	console_screen_checker screen_watch (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.char_code    (char_code),
		.cell_index   (cell_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.cursor_index (cursor_index),
		.cell_data    (cell_data),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	// Receiver side: stall decided fresh each cycle at the falling edge.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < receiver_stall_pct);
	end

	// Watchdog: any accepted transaction on any channel restarts the count.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offers one command transaction. Called at a falling edge, returns at the
	// falling edge after acceptance with valid still high, so a following
	// command keeps valid up without a low glitch.
	task automatic send_command(input logic [CMD_W-1:0] op, input logic [CHAR_W-1:0] code,
			input logic [INDEX_W-1:0] where);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		char_code <= code;
		cell_index <= where;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Attribute write; only issued while nothing is in flight.
	task automatic write_attribute(input logic [ATTR_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Drop valid and wait until every predicted result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	// Random command mix. Line feeds are common enough that the cursor reaches
	// the bottom row early and scrolling is exercised many times; clears are
	// rare since each one costs a full screen walk. Reads lean toward the
	// bottom row, where fresh text lands after scrolling starts.
	task automatic send_random_command();
		int                 pick;
		int                 zone;
		logic [CHAR_W-1:0]  code;
		logic [INDEX_W-1:0] where;
		pick = $urandom_range(99);
		code = CHAR_W'($urandom);
		where = INDEX_W'($urandom);
		if (pick < 55)
			code = CHAR_W'($urandom_range(255, CODE_BLANK));
		else if (pick < 65)
			code = CODE_LF;
		else if (pick < 69)
			code = CODE_CR;
		else if (pick < 73)
			code = CODE_BS;
		else if (pick < 78)
			code = CODE_TAB;
		else if (pick < 81)
			code = CHAR_W'($urandom_range(CODE_BLANK - 1, 0));
		if (pick < 81) begin
			send_command(CMD_PUT, code, where);
		end else if (pick < 83) begin
			send_command(CMD_CLEAR, code, where);
		end else if (pick < 98) begin
			zone = $urandom_range(99);
			if (zone < 40)
				where = INDEX_W'($urandom_range(CELLS - 1, CELLS - COLUMNS_DEF));
			else if (zone < 85)
				where = INDEX_W'($urandom_range(CELLS - 1, 0));
			else
				where = INDEX_W'($urandom_range(2 ** INDEX_W - 1, CELLS));
			send_command(CMD_READ, code, where);
		end else begin
			send_command(CMD_UNUSED, code, where);
		end
	endtask

	initial begin
		int attr_plan [4];
		int idle_plan [4];
		int stall_plan [4];

		// attribute extremes first, then two random settings
		attr_plan = '{8'h00, 8'hFF, $urandom_range(255), $urandom_range(255)};
		// no idling, sender idle, receiver stalling, both
		idle_plan = '{0, 71, 0, 24};
		stall_plan = '{0, 0, 71, 24};

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part, reset attribute 0x0F, cursor starts at home.
		// Reset contents and out-of-range reads, including the all-ones index.
		send_command(CMD_READ, 8'h00, 11'd0);
		send_command(CMD_READ, 8'h00, 11'(CELLS - 1));
		send_command(CMD_READ, 8'h00, 11'(CELLS));
		send_command(CMD_READ, 8'hFF, 11'h7FF);
		// printable extremes, then read one back
		send_command(CMD_PUT, CODE_BLANK, 11'd0);
		send_command(CMD_PUT, 8'hFF, 11'h7FF);
		send_command(CMD_PUT, 8'h41, 11'd0);
		send_command(CMD_READ, 8'h00, 11'd1);
		// backspace, carriage return, backspace pinned at column zero
		send_command(CMD_PUT, CODE_BS, 11'd0);
		send_command(CMD_PUT, CODE_CR, 11'd0);
		send_command(CMD_PUT, CODE_BS, 11'd0);
		// other control codes leave everything alone
		send_command(CMD_PUT, 8'h00, 11'd0);
		send_command(CMD_PUT, 8'h1F, 11'd0);
		// overwrite column zero, then tab onto a stop and from that stop to the next
		send_command(CMD_PUT, 8'h7F, 11'd0);
		send_command(CMD_PUT, CODE_TAB, 11'd0);
		send_command(CMD_PUT, CODE_TAB, 11'd0);
		send_command(CMD_PUT, CODE_LF, 11'd0);
		// unused command with all field bits set
		send_command(CMD_UNUSED, 8'hFF, 11'h7FF);
		send_command(CMD_READ, 8'h00, 11'd0);
		// clear ignores its payload fields
		send_command(CMD_CLEAR, 8'hFF, 11'h7FF);
		send_command(CMD_READ, 8'h00, 11'd0);
		send_command(CMD_PUT, 8'h5A, 11'd0);
		send_command(CMD_READ, 8'h00, 11'd0);
		drain_results();

		// Random phases; the attribute changes only with the block idle.
		for (int p = 0; p < 4; p++) begin
			sender_idle_pct = idle_plan[p];
			receiver_stall_pct = stall_plan[p];
			write_attribute(ATTR_W'(attr_plan[p]));
			repeat (RANDOM_PER_PHASE)
				send_random_command();
			drain_results();
		end

		// let any stray result show up before the verdict
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
